/* hw/rtl/tbs_pkg.sv */
// ============================================================================
// tbs_pkg
// Shared types, register indexes and the ordering rule of the tiered jet
// sorter.
// ============================================================================
`default_nettype none

package tbs_pkg;

    localparam int ID_W   = 8;
    localparam int PT_W   = 16;
    localparam int BTAG_W = 16;
    localparam int TIER_W = 2;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_WP_LOOSE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_WP_MEDIUM = 2'd1;
    localparam logic [IDX_W-1:0] REG_WP_TIGHT  = 2'd2;

    localparam logic [TIER_W-1:0] TIER_NONE   = 2'd0;
    localparam logic [TIER_W-1:0] TIER_LOOSE  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_MEDIUM = 2'd2;
    localparam logic [TIER_W-1:0] TIER_TIGHT  = 2'd3;

    localparam logic [CFG_W-1:0] WP_LOOSE_RST  = 16'd3211;
    localparam logic [CFG_W-1:0] WP_MEDIUM_RST = 16'd18239;
    localparam logic [CFG_W-1:0] WP_TIGHT_RST  = 16'd46530;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PT_W-1:0]   pt;
        logic [BTAG_W-1:0] btag;
        logic [TIER_W-1:0] tier;
    } jet_t;

    typedef struct packed {
        logic load;
        logic drain;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } tbs_state_t;

    // True when jet a must be placed strictly ahead of jet b.
    function automatic logic precedes(input jet_t a, input jet_t b);
        logic result;
        if (a.tier != b.tier)
        begin
            result = (a.tier > b.tier);
        end
        else if (a.tier != TIER_NONE)
        begin
            result = (a.pt > b.pt);
        end
        else
        begin
            result = (a.btag > b.btag);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tbs_cell.sv */
// ============================================================================
// tbs_cell
// One slot of the sorting row: holds a jet, shifts right on insertion ahead
// of it and shifts left while the row drains.
// ============================================================================
`default_nettype none

module tbs_cell
    import tbs_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire jet_t       new_jet,
    input  wire jet_t       left_jet,
    input  wire logic       left_ins,
    input  wire jet_t       right_jet,
    output jet_t            jet,
    output logic            ins
);

    jet_t jet_reg;
    jet_t jet_next;

    assign ins = occupied ? precedes(new_jet, jet_reg) : 1'b1;
    assign jet = jet_reg;

    always_comb
    begin
        jet_next = jet_reg;
        if (ctrl.drain)
        begin
            jet_next = right_jet;
        end
        else if (ctrl.load)
        begin
            if (left_ins)
            begin
                jet_next = left_jet;
            end
            else if (ins)
            begin
                jet_next = new_jet;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jet_reg <= jet_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/tiered_btag_pt_jet_sort_core.sv */
// ============================================================================
// tiered_btag_pt_jet_sort_core
// Sorts the jets of one event by b-tag tier, then pt or b-tag score, in a
// row of insertion cells and emits them after the last jet of the event.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  input     in_valid/in_ready, jet_id, jet_pt,        in
//            btag_score, last_jet
//  output    out_valid/out_ready, out_id, out_pt,      out
//            out_btag, tier, end_of_list, overflowed
//  config    cfg_wr_en, cfg_index, cfg_wr_data         in
//
// Each input beat is inserted into the cell row as it is taken, so loading
// runs at one jet per cycle; beats beyond MAX_JETS are dropped and flagged
// as overflowed. After the last jet, the row drains from its head at one
// beat per cycle while out_ready is high. Input is not taken while the burst
// drains; an output stall holds the row. Reset empties the row at once.
`default_nettype none

module tiered_btag_pt_jet_sort_core
    import tbs_pkg::*;
#(
    parameter int MAX_JETS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ID_W-1:0]   jet_id,
    input  wire logic [PT_W-1:0]   jet_pt,
    input  wire logic [BTAG_W-1:0] btag_score,
    input  wire logic              last_jet,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ID_W-1:0]        out_id,
    output logic [PT_W-1:0]        out_pt,
    output logic [BTAG_W-1:0]      out_btag,
    output logic [TIER_W-1:0]      tier,
    output logic                   end_of_list,
    output logic                   overflowed
);

    localparam int CNT_W = $clog2(MAX_JETS + 1);

    tbs_state_t        state_reg;
    tbs_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              drop_reg;
    logic              drop_next;
    logic [CFG_W-1:0]  wp_loose_reg;
    logic [CFG_W-1:0]  wp_medium_reg;
    logic [CFG_W-1:0]  wp_tight_reg;

    logic              in_fire;
    logic              out_fire;
    logic              full;
    cell_ctrl_t        ctrl;
    jet_t              new_jet;
    logic [TIER_W-1:0] new_tier;
    jet_t              cell_jet [MAX_JETS];
    logic              cell_ins [MAX_JETS];

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign full     = (count_reg == CNT_W'(MAX_JETS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_loose_reg  <= WP_LOOSE_RST;
            wp_medium_reg <= WP_MEDIUM_RST;
            wp_tight_reg  <= WP_TIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WP_LOOSE:  wp_loose_reg  <= cfg_wr_data;
                REG_WP_MEDIUM: wp_medium_reg <= cfg_wr_data;
                REG_WP_TIGHT:  wp_tight_reg  <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (btag_score > wp_tight_reg)
        begin
            new_tier = TIER_TIGHT;
        end
        else if (btag_score > wp_medium_reg)
        begin
            new_tier = TIER_MEDIUM;
        end
        else if (btag_score > wp_loose_reg)
        begin
            new_tier = TIER_LOOSE;
        end
        else
        begin
            new_tier = TIER_NONE;
        end
    end

    assign new_jet = '{id: jet_id, pt: jet_pt, btag: btag_score, tier: new_tier};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last_jet)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.drain = 1'b0;
        count_next = count_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    ctrl.drain = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        drop_next = 1'b0;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_JETS; i++)
        begin : g_cell
            jet_t left_jet;
            logic left_ins;
            jet_t right_jet;

            if (i == 0)
            begin : g_head
                assign left_jet = new_jet;
                assign left_ins = 1'b0;
            end
            else
            begin : g_body
                assign left_jet = cell_jet[i-1];
                assign left_ins = cell_ins[i-1];
            end

            if (i == MAX_JETS - 1)
            begin : g_tail
                assign right_jet = cell_jet[i];
            end
            else
            begin : g_inner
                assign right_jet = cell_jet[i+1];
            end

            tbs_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (CNT_W'(i) < count_reg),
                .new_jet   (new_jet),
                .left_jet  (left_jet),
                .left_ins  (left_ins),
                .right_jet (right_jet),
                .jet       (cell_jet[i]),
                .ins       (cell_ins[i])
            );
        end
    endgenerate

    assign out_id      = cell_jet[0].id;
    assign out_pt      = cell_jet[0].pt;
    assign out_btag    = cell_jet[0].btag;
    assign tier        = cell_jet[0].tier;
    assign end_of_list = (count_reg == CNT_W'(1));
    assign overflowed  = drop_reg;

endmodule

`default_nettype wire

/* hw/rtl/tbs_checker.sv */
// ============================================================================
// tbs_checker
// Port-level checks of the jet sorter's load and burst sequencing.
// ============================================================================
`default_nettype none

module tbs_checker
    import tbs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic last_jet,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic end_of_list,
    input wire logic overflowed
);

    // The block never takes a jet while a burst is on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
    else $error("input taken during a burst");

    // The last jet of an event starts the burst on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_jet) |=> out_valid)
    else $error("burst did not start after the last jet");

    // The final beat of a burst ends it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_list) |=> !out_valid)
    else $error("burst continued past the end of the list");

    // A burst runs without gaps and keeps its overflow flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !end_of_list) |=>
            (out_valid && (overflowed == $past(overflowed))))
    else $error("burst broke off or changed its overflow flag");

endmodule

bind tiered_btag_pt_jet_sort_core tbs_checker u_tbs_checker (.*);

`default_nettype wire

/* test/tiered_btag_pt_jet_sort_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// tiered_btag_pt_jet_sort_checker
// Watches the configuration port and both channels of the jet sorter. It
// keeps its own copy of the working points and the stored jets, and ranks
// each event when its last jet is taken. Each output beat is compared with
// the oldest ranked jet still waiting. The module reports the failure count
// and the number of ranked jets that have not come out yet.
// ============================================================================

module tiered_btag_pt_jet_sort_checker
    import tbs_pkg::*;
#(
    parameter int MAX_JETS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [ID_W-1:0]   jet_id,
    input  wire logic [PT_W-1:0]   jet_pt,
    input  wire logic [BTAG_W-1:0] btag_score,
    input  wire logic              last_jet,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [ID_W-1:0]   out_id,
    input  wire logic [PT_W-1:0]   out_pt,
    input  wire logic [BTAG_W-1:0] out_btag,
    input  wire logic [TIER_W-1:0] tier,
    input  wire logic              end_of_list,
    input  wire logic              overflowed,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PT_W-1:0]   pt;
        logic [BTAG_W-1:0] btag;
        logic [TIER_W-1:0] tier;
        logic              eol;
        logic              ovf;
    } ranked_jet_t;

    logic [CFG_W-1:0] loose_thr;
    logic [CFG_W-1:0] medium_thr;
    logic [CFG_W-1:0] tight_thr;
    jet_t             stored_jets [MAX_JETS];
    int               stored_n;
    logic             overflow_seen;
    ranked_jet_t      ranked_jets_q [$];
    int               fail_count;

    function automatic logic [TIER_W-1:0] tier_of(input logic [BTAG_W-1:0] score);
        if (score > tight_thr)
        begin
            return TIER_TIGHT;
        end
        if (score > medium_thr)
        begin
            return TIER_MEDIUM;
        end
        if (score > loose_thr)
        begin
            return TIER_LOOSE;
        end
        return TIER_NONE;
    endfunction

    function automatic logic ahead_of(input jet_t a, input jet_t b);
        if (a.tier != b.tier)
        begin
            return a.tier > b.tier;
        end
        if (a.tier != TIER_NONE)
        begin
            return a.pt > b.pt;
        end
        return a.btag > b.btag;
    endfunction

    function automatic string beat_text(input ranked_jet_t b);
        return $sformatf("id=%0d pt=%0d btag=%0d tier=%0d eol=%0b ovf=%0b",
                         b.id, b.pt, b.btag, b.tier, b.eol, b.ovf);
    endfunction

    function automatic void rank_event();
        jet_t        order [MAX_JETS];
        jet_t        cur;
        int          k;
        ranked_jet_t r;
        for (int i = 0; i < stored_n; i++)
        begin
            order[i] = stored_jets[i];
        end
        for (int i = 1; i < stored_n; i++)
        begin
            cur = order[i];
            k = i;
            while (k > 0 && ahead_of(cur, order[k-1]))
            begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = cur;
        end
        for (int i = 0; i < stored_n; i++)
        begin
            r.id   = order[i].id;
            r.pt   = order[i].pt;
            r.btag = order[i].btag;
            r.tier = order[i].tier;
            r.eol  = (i == stored_n - 1);
            r.ovf  = overflow_seen;
            ranked_jets_q.insert(ranked_jets_q.size(), r);
        end
    endfunction

    function automatic void take_jet();
        jet_t j;
        if (stored_n < MAX_JETS)
        begin
            j.id   = jet_id;
            j.pt   = jet_pt;
            j.btag = btag_score;
            j.tier = tier_of(btag_score);
            stored_jets[stored_n] = j;
            stored_n++;
        end
        else
        begin
            overflow_seen = 1'b1;
        end
        if (last_jet)
        begin
            rank_event();
            stored_n = 0;
            overflow_seen = 1'b0;
        end
    endfunction

    function automatic void check_beat();
        ranked_jet_t got;
        ranked_jet_t want;
        got = '{out_id, out_pt, out_btag, tier, end_of_list, overflowed};
        if (ranked_jets_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%0t: output beat with nothing expected: %s",
                         $realtime, beat_text(got));
            end
            return;
        end
        want = ranked_jets_q.pop_front();
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%0t: beat mismatch: expected %s", $realtime, beat_text(want));
                $display("%0t:                actual   %s", $realtime, beat_text(got));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loose_thr = WP_LOOSE_RST;
            medium_thr = WP_MEDIUM_RST;
            tight_thr = WP_TIGHT_RST;
            stored_n = 0;
            overflow_seen = 1'b0;
            ranked_jets_q.delete();
            fail_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WP_LOOSE:  loose_thr = cfg_wr_data;
                    REG_WP_MEDIUM: medium_thr = cfg_wr_data;
                    REG_WP_TIGHT:  tight_thr = cfg_wr_data;
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                check_beat();
            end
            if (in_valid && in_ready)
            begin
                take_jet();
            end
            mismatches <= fail_count;
            pending <= ranked_jets_q.size();
        end
    end

endmodule

/* test/tiered_btag_pt_jet_sort_core_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tiered_btag_pt_jet_sort_core_tb
// Drives events of jets into the tiered jet sorter under several sets of
// working points, including all-zero, all-ones and reversed ones. A short
// directed part covers threshold boundaries, field extremes and ties; the
// rest is random events, some of them over capacity. Both channels idle at
// random outside one phase; the checker beside the block predicts each beat.
// ============================================================================

module tiered_btag_pt_jet_sort_core_tb
    import tbs_pkg::*;
();

    localparam int MAX_JETS      = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_JETS    = 70;
    localparam int PHASE_COUNT   = 6;
    localparam int SETTLE_CYCLES = 48;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_WP_LOOSE;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ID_W-1:0]   jet_id = '0;
    logic [PT_W-1:0]   jet_pt = '0;
    logic [BTAG_W-1:0] btag_score = '0;
    logic              last_jet = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ID_W-1:0]   out_id;
    logic [PT_W-1:0]   out_pt;
    logic [BTAG_W-1:0] out_btag;
    logic [TIER_W-1:0] tier;
    logic              end_of_list;
    logic              overflowed;
    int                mismatches;
    int                pending;

    bit                send_gaps = 1'b1;
    bit                sink_stalls = 1'b1;
    int                cycle_count = 0;
    logic [CFG_W-1:0]  loose_now = WP_LOOSE_RST;
    logic [CFG_W-1:0]  medium_now = WP_MEDIUM_RST;
    logic [CFG_W-1:0]  tight_now = WP_TIGHT_RST;

    tiered_btag_pt_jet_sort_core #(
        .MAX_JETS(MAX_JETS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .jet_id(jet_id),
        .jet_pt(jet_pt),
        .btag_score(btag_score),
        .last_jet(last_jet),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_id(out_id),
        .out_pt(out_pt),
        .out_btag(out_btag),
        .tier(tier),
        .end_of_list(end_of_list),
        .overflowed(overflowed)
    );

    tiered_btag_pt_jet_sort_checker #(
        .MAX_JETS(MAX_JETS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .jet_id(jet_id),
        .jet_pt(jet_pt),
        .btag_score(btag_score),
        .last_jet(last_jet),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_id(out_id),
        .out_pt(out_pt),
        .out_btag(out_btag),
        .tier(tier),
        .end_of_list(end_of_list),
        .overflowed(overflowed),
        .mismatches(mismatches),
        .pending(pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= !(sink_stalls && ($urandom_range(99) < 7));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tiered_btag_pt_jet_sort_core_tb: done, errors");
            $finish;
        end
    end

    // Valid is left high after a beat so that back-to-back jets need no toggle.
    task automatic send_jet(input logic [ID_W-1:0] id, input logic [PT_W-1:0] pt,
                            input logic [BTAG_W-1:0] score, input logic is_last);
        while (send_gaps && ($urandom_range(99) < 7))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        jet_id <= id;
        jet_pt <= pt;
        btag_score <= score;
        last_jet <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_working_points(input logic [CFG_W-1:0] loose,
                                       input logic [CFG_W-1:0] med,
                                       input logic [CFG_W-1:0] tight);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WP_LOOSE;
        cfg_wr_data <= loose;
        @(posedge clk);
        cfg_index <= REG_WP_MEDIUM;
        cfg_wr_data <= med;
        @(posedge clk);
        cfg_index <= REG_WP_TIGHT;
        cfg_wr_data <= tight;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        loose_now = loose;
        medium_now = med;
        tight_now = tight;
    endtask

    function automatic logic [BTAG_W-1:0] pick_score();
        logic [CFG_W-1:0] near_wp;
        int               pick;
        pick = $urandom_range(7);
        case (pick)
            0:       near_wp = loose_now;
            1:       near_wp = medium_now;
            2:       near_wp = tight_now;
            default: return BTAG_W'($urandom_range(65535));
        endcase
        pick = $urandom_range(2);
        if (pick == 0 && near_wp != '0)
        begin
            return near_wp - 1'b1;
        end
        if (pick == 2 && near_wp != '1)
        begin
            return near_wp + 1'b1;
        end
        return near_wp;
    endfunction

    function automatic logic [PT_W-1:0] pick_pt();
        case ($urandom_range(5))
            0:       return PT_W'($urandom_range(3));
            1:       return '1;
            2:       return '0;
            default: return PT_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic int pick_event_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            return MAX_JETS;
        end
        if (roll < 27)
        begin
            return $urandom_range(MAX_JETS + 4, MAX_JETS + 1);
        end
        return $urandom_range(MAX_JETS - 1, 1);
    endfunction

    task automatic send_event(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_jet(ID_W'($urandom_range(255)), pick_pt(), pick_score(), i == n - 1);
        end
    endtask

    initial
    begin
        int               phase_jets;
        int               n;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] mid;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scores on both sides of each reset working point, plus field extremes.
        send_jet(8'h00, 16'd0, 16'd0, 1'b0);
        send_jet(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_jet(8'h11, 16'd100, WP_LOOSE_RST, 1'b0);
        send_jet(8'h12, 16'd100, WP_LOOSE_RST + 16'd1, 1'b0);
        send_jet(8'h13, 16'd200, WP_MEDIUM_RST, 1'b0);
        send_jet(8'h14, 16'd300, WP_MEDIUM_RST + 16'd1, 1'b0);
        send_jet(8'h15, 16'd50, WP_TIGHT_RST, 1'b0);
        send_jet(8'h16, 16'd60, WP_TIGHT_RST + 16'd1, 1'b1);

        send_jet(8'h2A, 16'hFFFF, 16'd0, 1'b1);

        // Equal keys must come out in arrival order.
        send_jet(8'h31, 16'd500, 16'd20000, 1'b0);
        send_jet(8'h32, 16'd500, 16'd30000, 1'b0);
        send_jet(8'h33, 16'd500, 16'd25000, 1'b0);
        send_jet(8'h34, 16'd10, 16'd1000, 1'b0);
        send_jet(8'h35, 16'd20, 16'd1000, 1'b0);
        send_jet(8'h36, 16'd700, 16'd5000, 1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            case (phase)
                0: load_working_points('0, '0, '0);
                1: load_working_points('1, '1, '1);
                2: load_working_points(16'd50000, 16'd30000, 16'd10000);
                3:
                begin
                    lo = CFG_W'($urandom_range(20000));
                    mid = lo + CFG_W'($urandom_range(20000));
                    load_working_points(lo, mid, mid + CFG_W'($urandom_range(25000)));
                end
                default:
                begin
                    load_working_points(CFG_W'($urandom_range(65535)),
                                        CFG_W'($urandom_range(65535)),
                                        CFG_W'($urandom_range(65535)));
                end
            endcase
            send_gaps = (phase != 3);
            sink_stalls = (phase != 3);
            phase_jets = 0;
            while (phase_jets < PHASE_JETS)
            begin
                n = pick_event_size();
                send_event(n);
                phase_jets += n;
            end
        end
        settle();

        if (mismatches == 0 && pending == 0)
        begin
            $display("tiered_btag_pt_jet_sort_core_tb: done, clean");
        end
        else
        begin
            $display("tiered_btag_pt_jet_sort_core_tb: done, errors");
        end
        $finish;
    end

endmodule
